[design/sbdw_pkg.sv]
// ----------------------------------------------------------------------------
// sbdw_pkg: shared types and constants of the signed bcd digit writer
// Display codes, converter widths and the shift-add-3 step used by the
// binary to bcd stages.
// ----------------------------------------------------------------------------
package sbdw_pkg;

   // code-b display codes
   localparam logic [3:0] CODE_BLANK = 4'b1111;
   localparam logic [3:0] CODE_MINUS = 4'b1010;

   // converter sizing: |value| is at most 32768, five decimal digits
   localparam int VALUE_W    = 16;
   localparam int MAG_W      = VALUE_W + 1;
   localparam int BCD_DIGITS = 5;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int DD_W       = BCD_W + MAG_W;
   localparam int DD_STEPS   = 6;
   localparam int DD_STAGES  = (MAG_W + DD_STEPS - 1) / DD_STEPS;

   localparam int POS_W  = 3;
   localparam int CODE_W = 4;
   localparam int LEN_W  = 3;

   // one converter word: sign plus bcd digits over the remaining binary bits
   typedef struct packed {
      logic            neg;
      logic [DD_W-1:0] word;
   } dd_type;

   // converted value ready for the write sequencer
   typedef struct packed {
      logic             neg;
      logic [BCD_W-1:0] bcd;
      logic [LEN_W-1:0] length;
      logic             fits;
   } ser_item_type;

   // one shift-add-3 step: correct every digit of five or more, then shift
   function automatic logic [DD_W-1:0] dabble_step(input logic [DD_W-1:0] w);
      logic [DD_W-1:0] r;
      r = w;
      for (int n = 0; n < BCD_DIGITS; n++) begin
         if (r[MAG_W + 4*n +: 4] >= 4'd5) begin
            r[MAG_W + 4*n +: 4] = r[MAG_W + 4*n +: 4] + 4'd3;
         end
      end
      return r << 1;
   endfunction

   // the steps of one converter stage; stage s covers bits s*DD_STEPS upward
   function automatic logic [DD_W-1:0] dabble_run(input logic [DD_W-1:0] w,
                                                  input int stage);
      logic [DD_W-1:0] r;
      r = w;
      for (int j = 0; j < DD_STEPS; j++) begin
         if (stage * DD_STEPS + j < MAG_W) begin
            r = dabble_step(r);
         end
      end
      return r;
   endfunction

endpackage

[design/signed_bcd_digit_writer.sv]
// ----------------------------------------------------------------------------
// signed_bcd_digit_writer: signed value to code-b digit register writes
// Pipelined binary to bcd conversion followed by a write sequencer that
// emits one digit register write per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per signed 16-bit value on req_tdata.
//   rsp channel: one item per digit register write; tdata carries the digit
//   position and the code-b code, tlast marks the final write of a value.
//   Positions 1 to DIGIT_COUNT are written least significant first, with
//   blank above the number's length; a negative value adds a minus write at
//   position length+1. A value that does not fit causes no writes.
//   Path: a value passes the magnitude stage, three conversion stages,
//   the length stage and the sequencer register before its first write
//   is presented.
//   Writes: the sequencer emits one write per cycle while rsp_tready is
//   high; a value gives DIGIT_COUNT writes, DIGIT_COUNT+1 when negative;
//   a value that does not fit causes no write but leaves a gap in them.
//   Values enter back to back while earlier ones are still being written.
//   Reset clears all valid bits; no write is pending after reset.
//   When rsp_tready is low the current write holds and the pipeline fills
//   behind it, then req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_bcd_digit_writer #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: value[15:0]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sbdw_pkg::VALUE_W-1:0] req_tdata,
   // rsp_tdata: digit_position[2:0], digit_code[6:3], zero pad[7]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);
   import sbdw_pkg::*;

   localparam int CNT_W = $clog2(DIGIT_COUNT + 2);
   localparam logic [CNT_W-1:0] CNT_LAST_DIGIT = CNT_W'(DIGIT_COUNT);
   localparam logic [3:0]       DIGIT_COUNT_4  = 4'(DIGIT_COUNT);

   // stage 0 holds the magnitude, stages 1..DD_STAGES the conversion
   dd_type       dd_ff [0:DD_STAGES];
   dd_type       dd_in [0:DD_STAGES];
   logic         v_ff  [0:DD_STAGES+1];
   logic         take  [0:DD_STAGES+2];
   ser_item_type len_ff, len_in;

   // write sequencer
   ser_item_type     ser_ff, ser_in;
   logic             ser_valid_ff, ser_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             ser_take;
   logic             minus_phase;
   logic             last_write;
   logic [CNT_W-1:0] digit_idx;
   logic [3:0]       digit_val;
   logic [POS_W-1:0] pos_out;
   logic [CODE_W-1:0] code_out;

   logic [MAG_W-1:0] value_ext;
   logic [MAG_W-1:0] mag;
   logic [BCD_W-1:0] bcd_done;
   logic [LEN_W-1:0] length;

   // ready chain: a stage takes an item when empty or when it moves on
   always_comb begin
      take[DD_STAGES+2] = ser_take;
      for (int k = DD_STAGES + 1; k >= 0; k--) begin
         take[k] = !v_ff[k] || take[k+1];
      end
   end

   assign req_tready = take[0];

   // magnitude of the two's complement value, -32768 included
   assign value_ext = {req_tdata[VALUE_W-1], req_tdata};
   assign mag       = (value_ext ^ {MAG_W{req_tdata[VALUE_W-1]}})
                    + MAG_W'(req_tdata[VALUE_W-1]);

   always_comb begin
      dd_in[0].neg  = req_tdata[VALUE_W-1];
      dd_in[0].word = {{BCD_W{1'b0}}, mag};
      for (int s = 1; s <= DD_STAGES; s++) begin
         dd_in[s].neg  = dd_ff[s-1].neg;
         dd_in[s].word = dabble_run(dd_ff[s-1].word, s - 1);
      end
   end

   // length is the index of the highest nonzero digit, zero counts as one
   assign bcd_done = dd_ff[DD_STAGES].word[DD_W-1 -: BCD_W];

   always_comb begin
      length = LEN_W'(1);
      for (int d = 1; d < BCD_DIGITS; d++) begin
         if (bcd_done[4*d +: 4] != 4'd0) begin
            length = LEN_W'(d + 1);
         end
      end
      len_in.neg    = dd_ff[DD_STAGES].neg;
      len_in.bcd    = bcd_done;
      len_in.length = length;
      len_in.fits   = ({1'b0, length} <= DIGIT_COUNT_4)
                   && (!dd_ff[DD_STAGES].neg
                       || ({1'b0, length} + 4'd1 <= DIGIT_COUNT_4));
   end

   // pipeline registers: valid bits reset, payload loads on take
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DD_STAGES + 1; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (take[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k <= DD_STAGES + 1; k++) begin
            if (take[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DD_STAGES; s++) begin
         if (take[s]) begin
            dd_ff[s] <= dd_in[s];
         end
      end
      if (take[DD_STAGES+1]) begin
         len_ff <= len_in;
      end
   end

   // sequencer output decode from its registers
   assign minus_phase = cnt_ff > CNT_LAST_DIGIT;
   assign last_write  = minus_phase || (cnt_ff == CNT_LAST_DIGIT && !ser_ff.neg);
   assign digit_idx   = cnt_ff - CNT_W'(1);
   assign digit_val   = 4'(ser_ff.bcd >> {digit_idx, 2'b00});

   always_comb begin
      if (minus_phase) begin
         pos_out  = ser_ff.length + LEN_W'(1);
         code_out = CODE_MINUS;
      end else begin
         pos_out  = POS_W'(cnt_ff);
         code_out = (4'(cnt_ff) > {1'b0, ser_ff.length}) ? CODE_BLANK : digit_val;
      end
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata  = {1'b0, code_out, pos_out};
   assign rsp_tlast  = last_write;

   // sequencer is free when empty or when its final write is taken
   assign ser_take = !ser_valid_ff || (rsp_tready && last_write);

   // load a fitting item, drop one that fits not, else step to next write
   always_comb begin
      ser_in       = ser_ff;
      ser_valid_in = ser_valid_ff;
      cnt_in       = cnt_ff;
      if (ser_take) begin
         ser_in       = len_ff;
         ser_valid_in = v_ff[DD_STAGES+1] && len_ff.fits;
         cnt_in       = CNT_W'(1);
      end else if (rsp_tready) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_ff <= ser_in;
      cnt_ff <= cnt_in;
   end

endmodule
